// File: rtl/dmskt_pkg.sv
// ----------------------------------------------------------------------------
// dmskt_pkg
// shared widths and command codes of the direct-mapped string-key table
// ----------------------------------------------------------------------------
package dmskt_pkg;

    localparam int BYTE_W = 7;
    localparam int AGE_W  = 8;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

endpackage

// File: rtl/dmskt_hash_unit.sv
// ----------------------------------------------------------------------------
// dmskt_hash_unit
// hash step ((h + byte) * byte) mod SLOT_COUNT on one shared multiplier:
// product, reciprocal quotient estimate, then remainder, one per cycle
// ----------------------------------------------------------------------------
module dmskt_hash_unit
    import dmskt_pkg::*;
#(
    parameter int SLOT_COUNT = 15
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [$clog2(SLOT_COUNT)-1:0] hash_in,
    input  logic [BYTE_W-1:0]             key_byte,
    output logic                          done,
    output logic [$clog2(SLOT_COUNT)-1:0] hash_out
);

    localparam int HW     = $clog2(SLOT_COUNT);
    localparam int SUM_W  = $clog2(SLOT_COUNT + (1 << BYTE_W) - 1);
    localparam int PROD_W = SUM_W + BYTE_W;
    localparam int MUL_W  = 2 * PROD_W;

    // floor(2^PROD_W / SLOT_COUNT): the quotient estimate is low by at most one
    localparam logic [PROD_W-1:0] RECIP = PROD_W'((1 << PROD_W) / SLOT_COUNT);

    localparam logic [1:0] STEP_MUL   = 2'd0;
    localparam logic [1:0] STEP_RECIP = 2'd1;
    localparam logic [1:0] STEP_FOLD  = 2'd2;

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_b;
    logic [MUL_W-1:0]  mul_p;
    logic [PROD_W-1:0] rem;
    logic [PROD_W-1:0] rem_fix;

    logic [SUM_W-1:0]  sum_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] quot_reg;
    logic [1:0]        step_reg;
    logic              active_reg;

    assign sum = SUM_W'(hash_in) + SUM_W'(key_byte);

    always_comb
    begin
        case (step_reg)
            STEP_MUL:
            begin
                mul_a = PROD_W'(sum_reg);
                mul_b = PROD_W'(byte_reg);
            end
            STEP_RECIP:
            begin
                mul_a = prod_reg;
                mul_b = RECIP;
            end
            default:
            begin
                mul_a = quot_reg;
                mul_b = PROD_W'(SLOT_COUNT);
            end
        endcase
    end

    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

    // remainder lies below twice SLOT_COUNT, one subtract finishes it
    assign rem     = prod_reg - mul_p[PROD_W-1:0];
    assign rem_fix = (rem >= PROD_W'(SLOT_COUNT)) ? (rem - PROD_W'(SLOT_COUNT)) : rem;

    assign done     = active_reg && (step_reg == STEP_FOLD);
    assign hash_out = rem_fix[HW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= STEP_MUL;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            step_reg   <= STEP_MUL;
        end
        else if (done)
        begin
            active_reg <= 1'b0;
            step_reg   <= STEP_MUL;
        end
        else if (active_reg)
        begin
            step_reg <= step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg  <= sum;
            byte_reg <= key_byte;
        end
        if (active_reg && step_reg == STEP_MUL)
        begin
            prod_reg <= mul_p[PROD_W-1:0];
        end
        if (active_reg && step_reg == STEP_RECIP)
        begin
            quot_reg <= mul_p[MUL_W-1:PROD_W];
        end
    end

endmodule

// File: rtl/direct_mapped_string_key_table_top.sv
// ----------------------------------------------------------------------------
// direct_mapped_string_key_table_top
// one-way hashed table of string keys with insert, get and delete
// ----------------------------------------------------------------------------
// A key enters one byte per item; each byte with room in the key buffer keeps
// the block busy while the hash unit, on one shared multiplier, forms the
// product, a reciprocal quotient estimate and then the remainder modulo
// SLOT_COUNT, one per cycle. A byte past the buffer limit is dropped without a
// hash step. The last byte then adds a dispatch state plus a read state and a
// write or compare state for each key byte of the copy on a successful insert,
// or each compared byte on a get or delete whose stored length matches, up to
// the first byte that differs, as each byte goes through a registered read of
// the key buffer and the slot store. Each item that ends a key gives one
// result on status and found_age, flagged by done for exactly one cycle; the
// receiver cannot stall, so it must take the result in that cycle. The slot
// table is empty after reset.
// ----------------------------------------------------------------------------
module direct_mapped_string_key_table_top
    import dmskt_pkg::*;
#(
    parameter int SLOT_COUNT    = 15,
    parameter int KEY_BYTES_MAX = 255
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [BYTE_W-1:0] key_byte,
    input  logic              key_last,
    input  logic [AGE_W-1:0]  entry_age,
    output logic              done,
    output logic              status,
    output logic [AGE_W-1:0]  found_age
);

    localparam int HW    = $clog2(SLOT_COUNT);
    localparam int LW    = $clog2(KEY_BYTES_MAX + 1);
    localparam int IW    = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int TOTAL = SLOT_COUNT * KEY_BYTES_MAX;
    localparam int AW    = $clog2(TOTAL);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_HASH     = 7'b0000010,
        ST_DISPATCH = 7'b0000100,
        ST_COPY_RD  = 7'b0001000,
        ST_COPY_WR  = 7'b0010000,
        ST_CMP_RD   = 7'b0100000,
        ST_CMP      = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [HW-1:0]     hash_reg, hash_next;
    logic [LW-1:0]     key_len_reg, key_len_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     base_reg, base_next;
    logic              done_reg, done_next;
    logic              status_reg, status_next;
    logic [AGE_W-1:0]  found_reg, found_next;

    logic [CMD_W-1:0]  cmd_reg;
    logic [AGE_W-1:0]  age_reg;
    logic              last_reg;

    logic [SLOT_COUNT-1:0] slot_used_reg;
    logic [AGE_W-1:0]      slot_age_reg [SLOT_COUNT];
    logic [LW-1:0]         slot_len_reg [SLOT_COUNT];

    logic [BYTE_W-1:0] key_buf_mem  [KEY_BYTES_MAX];
    logic [BYTE_W-1:0] slot_key_mem [TOTAL];
    logic [BYTE_W-1:0] kb_rd_reg;
    logic [BYTE_W-1:0] sk_rd_reg;

    logic              accept;
    logic              room;
    logic              last_idx;
    logic [AW-1:0]     slot_addr;
    logic              hash_load;
    logic              hash_done;
    logic [HW-1:0]     hash_out;
    logic              set_used;
    logic              clr_used;
    logic              finish;
    logic              fin_status;
    logic [AGE_W-1:0]  fin_age;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign room      = (key_len_reg < LW'(KEY_BYTES_MAX));
    assign last_idx  = ((LW'(idx_reg) + LW'(1)) == key_len_reg);
    assign slot_addr = base_reg + AW'(idx_reg);

    assign done      = done_reg;
    assign status    = status_reg;
    assign found_age = found_reg;

    dmskt_hash_unit #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (hash_load),
        .hash_in  (hash_reg),
        .key_byte (key_byte),
        .done     (hash_done),
        .hash_out (hash_out)
    );

    always_comb
    begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        key_len_next = key_len_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        found_next   = found_reg;
        hash_load    = 1'b0;
        set_used     = 1'b0;
        clr_used     = 1'b0;
        finish       = 1'b0;
        fin_status   = 1'b1;
        fin_age      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        hash_load    = 1'b1;
                        key_len_next = key_len_reg + LW'(1);
                        state_next   = ST_HASH;
                    end
                    else if (key_last)
                    begin
                        // key already full: byte dropped, go straight to the command
                        state_next = ST_DISPATCH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    hash_next  = hash_out;
                    state_next = last_reg ? ST_DISPATCH : ST_IDLE;
                end
            end
            ST_DISPATCH:
            begin
                base_next = AW'(hash_reg) * AW'(KEY_BYTES_MAX);
                idx_next  = '0;
                if (cmd_reg == CMD_INSERT)
                begin
                    if (!slot_used_reg[hash_reg])
                    begin
                        set_used   = 1'b1;
                        state_next = ST_COPY_RD;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else if (cmd_reg == CMD_GET || cmd_reg == CMD_DELETE)
                begin
                    if (slot_used_reg[hash_reg] && slot_len_reg[hash_reg] == key_len_reg)
                    begin
                        state_next = ST_CMP_RD;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (last_idx)
                begin
                    finish     = 1'b1;
                    fin_status = 1'b0;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_COPY_RD;
                end
            end
            ST_CMP_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (kb_rd_reg != sk_rd_reg)
                begin
                    finish = 1'b1;
                end
                else if (last_idx)
                begin
                    finish     = 1'b1;
                    fin_status = 1'b0;
                    fin_age    = slot_age_reg[hash_reg];
                    clr_used   = (cmd_reg == CMD_DELETE);
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_CMP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next    = 1'b1;
            status_next  = fin_status;
            found_next   = fin_age;
            hash_next    = '0;
            key_len_next = '0;
            state_next   = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= '0;
            key_len_reg   <= '0;
            done_reg      <= 1'b0;
            slot_used_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            key_len_reg <= key_len_next;
            done_reg    <= done_next;
            if (set_used)
            begin
                slot_used_reg[hash_reg] <= 1'b1;
            end
            else if (clr_used)
            begin
                slot_used_reg[hash_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        base_reg   <= base_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        if (accept)
        begin
            cmd_reg  <= cmd;
            age_reg  <= entry_age;
            last_reg <= key_last;
        end
        if (set_used)
        begin
            slot_age_reg[hash_reg] <= age_reg;
            slot_len_reg[hash_reg] <= key_len_reg;
        end
    end

    // key buffer: written as bytes arrive, read during copy and compare
    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            key_buf_mem[key_len_reg[IW-1:0]] <= key_byte;
        end
        kb_rd_reg <= key_buf_mem[idx_reg];
    end

    // per-slot key bytes, one row of KEY_BYTES_MAX per slot
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COPY_WR)
        begin
            slot_key_mem[slot_addr] <= kb_rd_reg;
        end
        sk_rd_reg <= slot_key_mem[slot_addr];
    end

`ifndef SYNTHESIS
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_fail_no_age: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (found_age == '0))
        else $error("failed command returned an age");

    a_hash_range: assert property (@(posedge clk) disable iff (!rst_n)
        hash_reg < SLOT_COUNT)
        else $error("running hash out of slot range");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_len_reg <= KEY_BYTES_MAX)
        else $error("key length beyond buffer");

    a_key_restart: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (key_len_reg == '0 && hash_reg == '0))
        else $error("key state not cleared after result");
`endif

endmodule

// File: test/direct_mapped_string_key_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_string_key_table_top_tb
// self-checking bench for the direct-mapped string-key table: keys go in one
// byte per item, a local copy of the slot table predicts each reply, and the
// replies are compared field by field as they come out
// ----------------------------------------------------------------------------
module direct_mapped_string_key_table_top_tb;
    import dmskt_pkg::*;

    localparam int SLOTS       = 15;
    localparam int KEY_MAX     = 255;
    localparam int POOL_KEYS   = 10;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 600;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]  op;
        logic [BYTE_W-1:0] ch;
        logic              last;
        logic [AGE_W-1:0]  age;
        int                idle_pct;
        bit                wait_empty;
    } key_char_t;

    typedef struct {
        logic             status;
        logic [AGE_W-1:0] age;
    } table_reply_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic [CMD_W-1:0]  cmd       = CMD_INSERT;
    logic [BYTE_W-1:0] key_byte  = '0;
    logic              key_last  = 1'b0;
    logic [AGE_W-1:0]  entry_age = '0;
    logic              busy;
    logic              done;
    logic              status;
    logic [AGE_W-1:0]  found_age;

    key_char_t    char_feed[$];
    table_reply_t table_replies[$];
    logic         taken = 1'b0;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           queued_chars = 0;

    // predicted block state
    int                hash_acc = 0;
    int                buf_len  = 0;
    logic [BYTE_W-1:0] key_buf   [0:KEY_MAX-1];
    bit                slot_used [0:SLOTS-1];
    logic [AGE_W-1:0]  slot_age  [0:SLOTS-1];
    int                slot_len  [0:SLOTS-1];
    logic [BYTE_W-1:0] slot_chars[0:SLOTS-1][0:KEY_MAX-1];

    // stimulus scratch
    logic [BYTE_W-1:0] key_chars [0:KEY_MAX+9];
    logic [BYTE_W-1:0] pool_chars[0:POOL_KEYS-1][0:5];
    int                pool_len  [0:POOL_KEYS-1];

    direct_mapped_string_key_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .key_byte  (key_byte),
        .key_last  (key_last),
        .entry_age (entry_age),
        .done      (done),
        .status    (status),
        .found_age (found_age)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
            slot_used[s] = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    task automatic table_step(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] ch,
                              input logic last, input logic [AGE_W-1:0] age);
        table_reply_t r;
        int           slot;
        bit           same;
        int           i;
        if (buf_len < KEY_MAX)
        begin
            hash_acc = ((hash_acc + int'(ch)) * int'(ch)) % SLOTS;
            key_buf[buf_len] = ch;
            buf_len++;
        end
        if (last)
        begin
            slot = hash_acc;
            r.status = 1'b1;
            r.age = '0;
            same = slot_used[slot] && (slot_len[slot] == buf_len);
            if (same)
                for (i = 0; i < buf_len; i++)
                    if (slot_chars[slot][i] !== key_buf[i])
                        same = 1'b0;
            case (op)
                CMD_INSERT:
                begin
                    if (!slot_used[slot])
                    begin
                        slot_used[slot] = 1'b1;
                        slot_age[slot] = age;
                        slot_len[slot] = buf_len;
                        for (i = 0; i < buf_len; i++)
                            slot_chars[slot][i] = key_buf[i];
                        r.status = 1'b0;
                    end
                end
                CMD_GET, CMD_DELETE:
                begin
                    if (same)
                    begin
                        r.status = 1'b0;
                        r.age = slot_age[slot];
                        if (op == CMD_DELETE)
                            slot_used[slot] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            table_replies.push_back(r);
            hash_acc = 0;
            buf_len = 0;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        table_reply_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (table_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply: expected none, actual status=%0b age=%0d",
                             $time, status, found_age);
                    mismatches++;
                end
                else
                begin
                    want = table_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0b, actual %0b",
                                 $time, want.status, status);
                        mismatches++;
                    end
                    if (found_age !== want.age)
                    begin
                        $display("%0t: found_age mismatch: expected %0d, actual %0d",
                                 $time, want.age, found_age);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                table_step(cmd, key_byte, key_last, entry_age);
            taken <= start && !busy;
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout, nothing accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin : driver
        key_char_t it;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || taken)
        begin
            if (char_feed.size() == 0)
                start <= 1'b0;
            else if (char_feed[0].wait_empty)
            begin
                start <= 1'b0;
                if (table_replies.size() == 0)
                    char_feed.delete(0);
            end
            else if ($urandom_range(99) < char_feed[0].idle_pct)
                start <= 1'b0;
            else
            begin
                it = char_feed.pop_front();
                cmd       <= it.op;
                key_byte  <= it.ch;
                key_last  <= it.last;
                entry_age <= it.age;
                start     <= 1'b1;
            end
        end
    end

    // queue key_chars[0 .. len-1] as one key
    task automatic add_key(input logic [CMD_W-1:0] op, input int len,
                           input logic [AGE_W-1:0] age, input int idle_pct);
        key_char_t it;
        for (int i = 0; i < len; i++)
        begin
            it.op = op;
            it.ch = key_chars[i];
            it.last = (i == len - 1);
            it.age = (i == len - 1) ? age : 8'($urandom);
            it.idle_pct = idle_pct;
            it.wait_empty = 1'b0;
            char_feed.push_back(it);
            queued_chars++;
        end
    endtask

    task automatic add_pause();
        key_char_t it;
        it.op = CMD_INSERT;
        it.ch = '0;
        it.last = 1'b0;
        it.age = '0;
        it.idle_pct = 0;
        it.wait_empty = 1'b1;
        char_feed.push_back(it);
    endtask

    function automatic logic [BYTE_W-1:0] random_char();
        if ($urandom_range(23) == 0)
            return '0;
        return BYTE_W'($urandom_range(1, 127));
    endfunction

    task automatic add_random_key(input int idle_pct);
        int               pick;
        int               len;
        logic [CMD_W-1:0] op;
        pick = $urandom_range(99);
        if (pick < 35)
            op = CMD_INSERT;
        else if (pick < 65)
            op = CMD_GET;
        else if (pick < 93)
            op = CMD_DELETE;
        else
            op = CMD_UNUSED;
        if ($urandom_range(99) < 85)
        begin
            pick = $urandom_range(POOL_KEYS - 1);
            len = pool_len[pick];
            for (int i = 0; i < len; i++)
                key_chars[i] = pool_chars[pick][i];
        end
        else
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                key_chars[i] = random_char();
        end
        add_key(op, len, 8'($urandom), idle_pct);
    endtask

    initial
    begin : stimulus
        int target;
        int h;
        int phase_idle[0:2];
        phase_idle[0] = 13;
        phase_idle[1] = 60;
        phase_idle[2] = 0;
        for (int p = 0; p < POOL_KEYS; p++)
        begin
            pool_len[p] = $urandom_range(1, 4);
            for (int i = 0; i < 6; i++)
                pool_chars[p][i] = random_char();
        end

        // single-char keys 1 and 4 share a slot
        key_chars[0] = 7'd1;
        add_key(CMD_INSERT, 1, 8'h00, 0);
        key_chars[0] = 7'd4;
        add_key(CMD_INSERT, 1, 8'hff, 0);
        add_key(CMD_GET, 1, 8'h00, 0);
        key_chars[0] = 7'd1;
        add_key(CMD_GET, 1, 8'h33, 0);
        key_chars[0] = 7'd127;
        add_key(CMD_INSERT, 1, 8'hff, 0);
        add_key(CMD_GET, 1, 8'h00, 0);
        // zero char is an ordinary key char
        key_chars[0] = 7'd0;
        add_key(CMD_GET, 1, 8'h00, 0);
        add_key(CMD_INSERT, 1, 8'h5a, 0);
        add_key(CMD_GET, 1, 8'h00, 0);
        key_chars[0] = 7'd1;
        key_chars[1] = 7'd127;
        add_key(CMD_GET, 2, 8'h00, 0);
        key_chars[0] = 7'd127;
        add_key(CMD_DELETE, 1, 8'h00, 0);
        add_key(CMD_GET, 1, 8'h00, 0);
        add_key(CMD_DELETE, 1, 8'h00, 0);
        // unused code leaves the table alone
        key_chars[0] = 7'd1;
        add_key(CMD_UNUSED, 1, 8'haa, 0);
        add_key(CMD_GET, 1, 8'h00, 0);
        key_chars[0] = 7'd127;
        key_chars[1] = 7'd127;
        key_chars[2] = 7'd127;
        add_key(CMD_INSERT, 3, 8'ha5, 0);
        add_key(CMD_GET, 3, 8'h00, 0);
        add_key(CMD_DELETE, 3, 8'h00, 0);
        add_pause();

        // over-long keys: only the first KEY_MAX chars count; slots 0 and 1 are taken
        do
        begin
            h = 0;
            for (int i = 0; i < KEY_MAX + 5; i++)
                key_chars[i] = random_char();
            for (int i = 0; i < KEY_MAX; i++)
                h = ((h + int'(key_chars[i])) * int'(key_chars[i])) % SLOTS;
        end
        while (h < 2);
        add_key(CMD_INSERT, KEY_MAX + 1, 8'h81, 0);
        for (int i = KEY_MAX; i < KEY_MAX + 5; i++)
            key_chars[i] = ~key_chars[i];
        add_key(CMD_DELETE, KEY_MAX + 3, 8'h00, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            add_pause();
            target = queued_chars + 22;
            while (queued_chars < target)
                add_random_key(phase_idle[ph]);
        end

        @(posedge clk);
        while (!rst_n || char_feed.size() != 0 || start)
            @(posedge clk);
        while (table_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/dmskt_pkg.sv
rtl/dmskt_hash_unit.sv
rtl/direct_mapped_string_key_table_top.sv
test/direct_mapped_string_key_table_top_tb.sv
